FILE: hw/rtl/cfbf_pkg.sv
// Types, constants and helpers shared by the corner fillet fan datapath.
package cfbf_pkg;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 6;
  localparam int WT_W    = 17;
  localparam int PROD_W  = WT_W + COORD_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ADDR_W  = 2;

  localparam logic [WT_W-1:0]   K_Q16    = 17'd47186;
  localparam logic [WT_W-1:0]   NK_Q16   = 17'd18350;
  localparam logic [WT_W-1:0]   HALF_Q16 = 17'd32768;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_CORNER = 2'd0;

  typedef struct packed {
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
  } box_t;

  typedef struct packed {
    logic [IDX_W-1:0]   vertex_index;
    logic [COORD_W-1:0] vertex_x;
    logic [COORD_W-1:0] vertex_y;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic               valid;
    logic               is_hub;
    logic               last;
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [1:0]         corner;
  } seq_t;

  typedef struct packed {
    logic                          valid;
    logic                          is_hub;
    logic                          zero;
    logic                          last;
    logic [IDX_W-1:0]              index;
    logic [COORD_W-1:0]            hub_x;
    logic [COORD_W-1:0]            hub_y;
    logic [3:0][COORD_W-1:0]       px;
    logic [3:0][COORD_W-1:0]       py;
    logic [3:0][WT_W-1:0]          wt;
  } pts_t;

  typedef struct packed {
    logic                          valid;
    logic                          is_hub;
    logic                          zero;
    logic                          last;
    logic [IDX_W-1:0]              index;
    logic [COORD_W-1:0]            hub_x;
    logic [COORD_W-1:0]            hub_y;
    logic [3:0][PROD_W-1:0]        prod_x;
    logic [3:0][PROD_W-1:0]        prod_y;
  } prod_t;

  // (d * k + 0.5) >> 16, never larger than d while k is at most 1.0 (65536)
  function automatic logic [COORD_W-1:0] scale_q16(input logic [COORD_W-1:0] d,
                                                   input logic [WT_W-1:0] k);
    logic [PROD_W-1:0] p;
    p = PROD_W'(d) * PROD_W'(k) + PROD_W'(HALF_Q16);
    return p[COORD_W+15:16];
  endfunction

endpackage

FILE: hw/rtl/cfbf_seq.sv
// Vertex sequencer: takes a box, issues one fan vertex slot per cycle.
module cfbf_seq #(
  parameter int SEGMENTS = 48,
  parameter int CNT_W    = $clog2(SEGMENTS + 2),
  parameter int TAB_W    = $clog2(SEGMENTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cfbf_pkg::box_t       box,
  input  logic [1:0]           corner,
  output cfbf_pkg::seq_t       seq,
  output logic [TAB_W-1:0]     seg
);
  import cfbf_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SEGMENTS + 1);

  logic               active;
  logic [CNT_W-1:0]   cnt;
  logic [COORD_W-1:0] width;
  logic [COORD_W-1:0] height;
  logic [1:0]         corner_held;
  logic               at_last;
  logic               accept;

  assign at_last = (cnt == LAST_CNT);
  assign busy    = active && !at_last;
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (at_last) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      width       <= box.box_width;
      height      <= box.box_height;
      corner_held <= corner;
    end
  end

  always_comb begin
    seq.valid  = active;
    seq.is_hub = (cnt == '0);
    seq.last   = at_last;
    seq.index  = IDX_W'(cnt);
    seq.width  = width;
    seq.height = height;
    seq.corner = corner_held;
    seg        = (cnt == '0) ? '0 : TAB_W'(cnt - 1'b1);
  end

endmodule

FILE: hw/rtl/cfbf_setup.sv
// Stage 1: Bernstein weight lookup and control point selection.
module cfbf_setup #(
  parameter int SEGMENTS = 48,
  parameter int TAB_W    = $clog2(SEGMENTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfbf_pkg::seq_t       seq,
  input  logic [TAB_W-1:0]     seg,
  output cfbf_pkg::pts_t       pts
);
  import cfbf_pkg::*;

  logic [3:0][WT_W-1:0] wt_tab [SEGMENTS+1];

  // Q1.16 weights, rounded half up, worked out at elaboration
  for (genvar i = 0; i <= SEGMENTS; i++) begin : g_wt
    localparam longint S  = SEGMENTS;
    localparam longint T  = i;
    localparam longint U  = SEGMENTS - i;
    localparam longint S3 = S * S * S;
    localparam longint W0 = (U * U * U * 65536 + S3 / 2) / S3;
    localparam longint W1 = (3 * T * U * U * 65536 + S3 / 2) / S3;
    localparam longint W2 = (3 * T * T * U * 65536 + S3 / 2) / S3;
    localparam longint W3 = (T * T * T * 65536 + S3 / 2) / S3;
    assign wt_tab[i] = {WT_W'(W3), WT_W'(W2), WT_W'(W1), WT_W'(W0)};
  end

  logic [COORD_W-1:0] wk, wnk, hk, hnk, w, h;
  pts_t               pts_next;

  assign w   = seq.width;
  assign h   = seq.height;
  assign wk  = scale_q16(w, K_Q16);
  assign wnk = scale_q16(w, NK_Q16);
  assign hk  = scale_q16(h, K_Q16);
  assign hnk = scale_q16(h, NK_Q16);

  always_comb begin
    pts_next.valid  = seq.valid;
    pts_next.is_hub = seq.is_hub;
    pts_next.last   = seq.last;
    pts_next.index  = seq.index;
    pts_next.zero   = (w == '0) || (h == '0);
    pts_next.wt     = wt_tab[seg];
    unique case (seq.corner)
      CORNER_TL: begin
        pts_next.hub_x = '0; pts_next.hub_y = h;
        pts_next.px = {w,  wk,  COORD_W'(0), COORD_W'(0)};
        pts_next.py = {h,  h,   hnk,         COORD_W'(0)};
      end
      CORNER_TR: begin
        pts_next.hub_x = w;  pts_next.hub_y = h;
        pts_next.px = {COORD_W'(0), wnk, w,   w};
        pts_next.py = {h,           h,   hnk, COORD_W'(0)};
      end
      CORNER_BR: begin
        pts_next.hub_x = w;  pts_next.hub_y = '0;
        pts_next.px = {COORD_W'(0), wnk,         w,  w};
        pts_next.py = {COORD_W'(0), COORD_W'(0), hk, h};
      end
      CORNER_BL: begin
        pts_next.hub_x = '0; pts_next.hub_y = '0;
        pts_next.px = {w,           wk,          COORD_W'(0), COORD_W'(0)};
        pts_next.py = {COORD_W'(0), COORD_W'(0), hk,          h};
      end
      default: begin
        pts_next.hub_x = '0; pts_next.hub_y = '0;
        pts_next.px = '0;
        pts_next.py = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pts <= '0;
    end else begin
      pts <= pts_next;
    end
  end

endmodule

FILE: hw/rtl/cfbf_blend.sv
// Stages 2 and 3: weighted products, then sum, round, saturate and output register.
module cfbf_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  cfbf_pkg::pts_t       pts,
  output logic                 vertex_valid,
  output cfbf_pkg::vertex_t    vertex
);
  import cfbf_pkg::*;

  prod_t             prod;
  prod_t             prod_next;
  logic [SUM_W-1:0]  sum_x, sum_y;
  logic [SUM_W-17:0] rnd_x, rnd_y;
  logic [COORD_W-1:0] sat_x, sat_y;
  vertex_t           vertex_next;

  always_comb begin
    prod_next.valid  = pts.valid;
    prod_next.is_hub = pts.is_hub;
    prod_next.zero   = pts.zero;
    prod_next.last   = pts.last;
    prod_next.index  = pts.index;
    prod_next.hub_x  = pts.hub_x;
    prod_next.hub_y  = pts.hub_y;
    for (int j = 0; j < 4; j++) begin
      prod_next.prod_x[j] = PROD_W'(pts.wt[j]) * PROD_W'(pts.px[j]);
      prod_next.prod_y[j] = PROD_W'(pts.wt[j]) * PROD_W'(pts.py[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod <= '0;
    end else begin
      prod <= prod_next;
    end
  end

  assign sum_x = SUM_W'(prod.prod_x[0]) + SUM_W'(prod.prod_x[1]) + SUM_W'(prod.prod_x[2])
               + SUM_W'(prod.prod_x[3]) + SUM_W'(HALF_Q16);
  assign sum_y = SUM_W'(prod.prod_y[0]) + SUM_W'(prod.prod_y[1]) + SUM_W'(prod.prod_y[2])
               + SUM_W'(prod.prod_y[3]) + SUM_W'(HALF_Q16);
  assign rnd_x = sum_x[SUM_W-1:16];
  assign rnd_y = sum_y[SUM_W-1:16];
  assign sat_x = (|rnd_x[SUM_W-17:COORD_W]) ? COORD_MAX : rnd_x[COORD_W-1:0];
  assign sat_y = (|rnd_y[SUM_W-17:COORD_W]) ? COORD_MAX : rnd_y[COORD_W-1:0];

  always_comb begin
    vertex_next.vertex_index = prod.index;
    vertex_next.last_vertex  = prod.last;
    priority if (prod.zero) begin
      vertex_next.vertex_x = '0;
      vertex_next.vertex_y = '0;
    end else if (prod.is_hub) begin
      vertex_next.vertex_x = prod.hub_x;
      vertex_next.vertex_y = prod.hub_y;
    end else begin
      vertex_next.vertex_x = sat_x;
      vertex_next.vertex_y = sat_y;
    end
  end

  always_ff @(posedge clk) begin
    vertex <= vertex_next;
    if (rst) begin
      vertex_valid <= 1'b0;
    end else begin
      vertex_valid <= prod.valid;
    end
  end

endmodule

FILE: hw/rtl/corner_fillet_bezier_fan.sv
// Top level of the corner fillet Bezier fan tessellator.
//
// Use: pulse start with a box (width, height, unsigned Q12.4) while busy is
// low; the item is taken at that edge. The block then emits a triangle fan
// of SEGMENTS+2 vertices, one per cycle, each marked by vertex_valid for a
// single cycle: the hub corner first, then the Bezier points from t=0 to 1.
// last_vertex flags the final one. A zero width or height gives all (0,0).
// The fillet orientation comes from corner_select, written over the APB
// port at address 0; the user is to write it only while the block is
// idle, which the block itself does not enforce. It is sampled per item.
// On its way out the hub vertex passes the weight/point, product and
// output registers behind the sequencer, which issues one vertex a cycle.
// busy drops in the cycle the last vertex is issued, so the next item
// follows with no gap in the output. The datapath is fully pipelined;
// every cycle one vertex moves a stage. Reset (synchronous, rst high)
// clears the sequencer, the stage valid bits and corner_select
// (top-left). The receiver cannot stall: every vertex is presented once
// and is gone the next cycle.
module corner_fillet_bezier_fan #(
  parameter int SEGMENTS = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  cfbf_pkg::box_t               box,
  output logic                         vertex_valid,
  output cfbf_pkg::vertex_t            vertex,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfbf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cfbf_pkg::*;

  localparam int TAB_W = $clog2(SEGMENTS + 1);

  logic [1:0]       corner_select;
  seq_t             seq;
  logic [TAB_W-1:0] seg;
  pts_t             pts;

  // Config port: pready tied high, one register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CORNER) ? {30'd0, corner_select} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_select <= CORNER_TL;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CORNER)) begin
      corner_select <= pwdata[1:0];
    end
  end

  // Stage 0: one vertex slot per cycle
  cfbf_seq #(.SEGMENTS(SEGMENTS)) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .box    (box),
    .corner (corner_select),
    .seq    (seq),
    .seg    (seg)
  );

  // Stage 1: weights from table, edge points pulled in by K
  cfbf_setup #(.SEGMENTS(SEGMENTS)) u_setup (
    .clk (clk),
    .rst (rst),
    .seq (seq),
    .seg (seg),
    .pts (pts)
  );

  // Stages 2-3: products, then rounded sum onto the result register
  cfbf_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .pts          (pts),
    .vertex_valid (vertex_valid),
    .vertex       (vertex)
  );

endmodule

FILE: hw/rtl/cfbf_chk.sv
// Port-level checks on the fan output sequence, bound to the top level.
module cfbf_chk (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                vertex_valid,
  input  cfbf_pkg::vertex_t   vertex
);
  import cfbf_pkg::*;

  // A fan is emitted without gaps
  a_fan_contiguous: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && !vertex.last_vertex |=> vertex_valid)
    else $error("gap inside a fan");

  // Indices step by one within a fan
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && !vertex.last_vertex |=>
      vertex.vertex_index == IDX_W'($past(vertex.vertex_index) + 1'b1))
    else $error("vertex index did not step");

  // A vertex straight after a fan's end opens a new fan at the hub
  a_new_fan_hub: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex.last_vertex |=> !vertex_valid || vertex.vertex_index == '0)
    else $error("new fan does not start at the hub");

  // A taken item keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after taking an item");

  // Nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !vertex_valid)
    else $error("vertex strobe after reset");

endmodule

bind corner_fillet_bezier_fan cfbf_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .vertex_valid (vertex_valid),
  .vertex       (vertex)
);
